// ----- src/uct_pkg.sv -----
package uct_pkg;

  localparam int NumSlotsDef = 8;
  localparam logic [15:0] FirstPortRst = 16'd1024;
  localparam logic [15:0] WrapLimitRst = 16'd32000;
  localparam logic [15:0] WrapBaseRst  = 16'd4096;
  localparam logic [7:0]  HopLimitRst  = 8'd64;

  localparam logic [2:0] CmdAlloc   = 3'd0;
  localparam logic [2:0] CmdFree    = 3'd1;
  localparam logic [2:0] CmdConnect = 3'd2;
  localparam logic [2:0] CmdEnable  = 3'd3;
  localparam logic [2:0] CmdDisable = 3'd4;
  localparam logic [2:0] CmdLookup  = 3'd5;

  localparam logic [1:0] StatDone    = 2'd0;
  localparam logic [1:0] StatNoFree  = 2'd1;
  localparam logic [1:0] StatNoMatch = 2'd2;

  localparam logic [1:0] RegFirstPort = 2'd0;
  localparam logic [1:0] RegWrapLimit = 2'd1;
  localparam logic [1:0] RegWrapBase  = 2'd2;
  localparam logic [1:0] RegHopLimit  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_LOOKUP,
    ST_SHIFT,
    ST_OUT
  } state_t;

endpackage

// ----- src/udp_connection_table.sv -----
// Path from acceptance to result valid: alloc, free, enable and unused commands go
// straight to the result state; disable passes through a shift state first; connect
// tries candidate ports (up to NUM_SLOTS + 2 candidates), reading every local port
// entry for each; lookup reads the active slots in order and stops at the first match.
// One command at a time: the next transaction is taken the cycle after the result is accepted.
// Reset: clearing pass over every entry of the local port memory, input stalled.
module udp_connection_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [2:0]  in_slot,
  input  logic        in_has_remote,
  input  logic [15:0] in_remote_port,
  input  logic [31:0] in_remote_addr,
  input  logic [15:0] in_pkt_dest_port,
  input  logic [15:0] in_pkt_src_port,
  input  logic [31:0] in_pkt_src_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [2:0]  out_found_slot,
  output logic [15:0] out_local_port,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import uct_pkg::*;

  localparam int NUM_SLOTS = uct_pkg::NumSlotsDef;
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int KW = $clog2(NUM_SLOTS + 3);

  state_t state_r, state_nxt;

  logic [15:0] first_port_r, wrap_limit_r, wrap_base_r, port_counter_r, port_counter_nxt;
  logic [7:0]  hop_limit_r;

  logic [AW-1:0] free_ring_r [NUM_SLOTS];
  logic [AW-1:0] free_head_r;
  logic [CW-1:0] free_count_r;
  logic [AW-1:0] active_r [NUM_SLOTS];
  logic [CW-1:0] active_count_r;

  logic [2:0]  cmd_r;
  logic [2:0]  slot_r;
  logic        has_remote_r;
  logic [15:0] rport_r, dport_r, sport_r;
  logic [31:0] raddr_r, saddr_r;

  logic [1:0]  ost_r;
  logic [2:0]  oslot_r;
  logic [15:0] oport_r;

  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [KW-1:0] tries_r, tries_nxt;
  logic          hit_r, hit_nxt;

  // memories
  logic          lp_we;
  logic [AW-1:0] lp_waddr, rd_addr;
  logic [15:0]   lp_wdata, lp_rdata, rp_rdata;
  logic [31:0]   ra_rdata;
  logic [7:0]    hl_rdata;
  logic          ep_we;
  logic [AW-1:0] rd_addr_r;

  uct_ram #(.Width(16), .Depth(NUM_SLOTS)) u_lport (
    .clk, .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
    .raddr(rd_addr), .rdata(lp_rdata));
  uct_ram #(.Width(16), .Depth(NUM_SLOTS)) u_rport (
    .clk, .we(ep_we), .waddr(slot_r[AW-1:0]),
    .wdata(has_remote_r ? rport_r : 16'd0), .raddr(rd_addr), .rdata(rp_rdata));
  uct_ram #(.Width(32), .Depth(NUM_SLOTS)) u_raddr (
    .clk, .we(ep_we), .waddr(slot_r[AW-1:0]),
    .wdata(has_remote_r ? raddr_r : 32'd0), .raddr(rd_addr), .rdata(ra_rdata));
  uct_ram #(.Width(8), .Depth(NUM_SLOTS)) u_hop (
    .clk, .we(ep_we), .waddr(slot_r[AW-1:0]),
    .wdata(hop_limit_r), .raddr(rd_addr), .rdata(hl_rdata));

  logic cfg_wr;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      RegFirstPort: cfg_prdata = {16'd0, first_port_r};
      RegWrapLimit: cfg_prdata = {16'd0, wrap_limit_r};
      RegWrapBase:  cfg_prdata = {16'd0, wrap_base_r};
      RegHopLimit:  cfg_prdata = {24'd0, hop_limit_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  logic slot_ok;
  assign slot_ok = ({29'd0, slot_r} < 32'(NUM_SLOTS));

  // free list membership and active position (small register lists)
  logic on_free;
  logic in_act;
  logic [CW-1:0] act_pos;
  always_comb begin
    logic [AW-1:0] p;
    on_free = 1'b0;
    in_act = 1'b0;
    act_pos = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      p = AW'((32'(free_head_r) + i) % NUM_SLOTS);
      if (i < 32'(free_count_r) && {29'd0, slot_r} == 32'(free_ring_r[p])) on_free = 1'b1;
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (i < 32'(active_count_r) && {29'd0, slot_r} == 32'(active_r[i])) begin
        in_act = 1'b1;
        act_pos = CW'(i);
      end
    end
  end

  // next candidate port
  logic [15:0] cand;
  always_comb begin
    cand = port_counter_r + 16'd1;
    if (cand >= wrap_limit_r) cand = wrap_base_r;
  end

  logic [AW-1:0] free_tail;
  assign free_tail = AW'((32'(free_head_r) + 32'(free_count_r)) % NUM_SLOTS);

  logic lk_match;
  assign lk_match = lp_rdata != 16'd0 && lp_rdata == dport_r &&
                    (rp_rdata == 16'd0 || rp_rdata == sport_r) &&
                    (ra_rdata == 32'd0 || ra_rdata == 32'hFFFF_FFFF || ra_rdata == saddr_r);

  // command-level list updates happen in the cycle after acceptance (ST_OUT entry, or ST_SHIFT for disable)
  logic first_out_r;

  // alloc/free port clear, in the cycle after acceptance
  logic alloc_now, free_now;
  assign alloc_now = first_out_r && state_r == ST_OUT && cmd_r == CmdAlloc;
  assign free_now  = first_out_r && state_r == ST_OUT && cmd_r == CmdFree && slot_ok;

  logic [1:0]  ost_nxt;
  logic [2:0]  oslot_nxt;
  logic [15:0] oport_nxt;
  logic        ac_shift_one;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    rd_pend_nxt = 1'b0;
    tries_nxt = tries_r;
    hit_nxt = hit_r;
    port_counter_nxt = port_counter_r;
    ost_nxt = ost_r;
    oslot_nxt = oslot_r;
    oport_nxt = oport_r;
    lp_we = 1'b0;
    lp_waddr = slot_r[AW-1:0];
    lp_wdata = 16'd0;
    ep_we = 1'b0;
    rd_addr = idx_r[AW-1:0];
    ac_shift_one = 1'b0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        lp_we = 1'b1;
        lp_waddr = idx_r[AW-1:0];
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(NUM_SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ost_nxt = StatDone;
        oslot_nxt = 3'd0;
        oport_nxt = 16'd0;
        idx_nxt = '0;
        hit_nxt = 1'b0;
        if (in_valid) begin
          state_nxt = ST_OUT;
          case (in_command)
            CmdAlloc: begin
              if (free_count_r == '0) ost_nxt = StatNoFree;
              else oslot_nxt = 3'(free_ring_r[free_head_r]);
            end
            CmdFree, CmdEnable: ;
            CmdConnect: if ({29'd0, in_slot} < 32'(NUM_SLOTS)) begin
              state_nxt = ST_SCAN;
              tries_nxt = '0;
            end
            CmdDisable: state_nxt = ST_SHIFT;
            CmdLookup: begin
              state_nxt = ST_LOOKUP;
              ost_nxt = StatNoMatch;
            end
            default: ;
          endcase
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (alloc_now && free_count_r != '0) begin
          lp_we = 1'b1;
          lp_waddr = free_ring_r[free_head_r];
        end
        if (free_now) begin
          lp_we = 1'b1;
          lp_waddr = slot_r[AW-1:0];
        end
        if (out_ready) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // one candidate: read every entry, compare, then decide
        if (idx_r == '0 && !rd_pend_r && !hit_r) begin
          port_counter_nxt = cand;
          tries_nxt = tries_r + KW'(1);
          rd_pend_nxt = 1'b1;
          rd_addr = '0;
          idx_nxt = CW'(1);
          hit_nxt = (cand == 16'd0);
        end else begin
          if (lp_rdata == port_counter_r) hit_nxt = 1'b1;
          if (idx_r < CW'(NUM_SLOTS)) begin
            rd_addr = idx_r[AW-1:0];
            rd_pend_nxt = 1'b1;
            idx_nxt = idx_r + CW'(1);
          end else begin
            idx_nxt = '0;
            if ((hit_nxt) && tries_r < KW'(NUM_SLOTS + 2)) begin
              hit_nxt = 1'b0;
            end else begin
              lp_we = 1'b1;
              lp_wdata = port_counter_r;
              ep_we = 1'b1;
              oport_nxt = port_counter_r;
              state_nxt = ST_OUT;
            end
          end
        end
      end
      ST_LOOKUP: begin
        if (rd_pend_r) begin
          if (lk_match) begin
            ost_nxt = StatDone;
            oslot_nxt = 3'(rd_addr_r);
            oport_nxt = lp_rdata;
            state_nxt = ST_OUT;
          end
        end else if (idx_r < active_count_r) begin
          rd_addr = active_r[idx_r[AW-1:0]];
          rd_pend_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SHIFT: begin
        ac_shift_one = 1'b1;
        state_nxt = ST_OUT;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr && cfg_paddr[3:2] == RegFirstPort) port_counter_nxt = cfg_pwdata[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r <= '0;
      rd_pend_r <= 1'b0;
      tries_r <= '0;
      hit_r <= 1'b0;
      first_port_r <= FirstPortRst;
      wrap_limit_r <= WrapLimitRst;
      wrap_base_r <= WrapBaseRst;
      hop_limit_r <= HopLimitRst;
      port_counter_r <= FirstPortRst;
      for (int i = 0; i < NUM_SLOTS; i++) free_ring_r[i] <= AW'(i);
      free_head_r <= '0;
      free_count_r <= CW'(NUM_SLOTS);
      active_count_r <= '0;
      first_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      rd_pend_r <= rd_pend_nxt;
      tries_r <= tries_nxt;
      hit_r <= hit_nxt;
      port_counter_r <= port_counter_nxt;
      first_out_r <= (state_r == ST_IDLE) && in_valid;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          RegFirstPort: first_port_r <= cfg_pwdata[15:0];
          RegWrapLimit: wrap_limit_r <= cfg_pwdata[15:0];
          RegWrapBase:  wrap_base_r <= cfg_pwdata[15:0];
          RegHopLimit:  hop_limit_r <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (first_out_r && state_r == ST_OUT) begin
        case (cmd_r)
          CmdAlloc: begin
            if (free_count_r != '0) begin
              free_head_r <= AW'((32'(free_head_r) + 1) % NUM_SLOTS);
              free_count_r <= free_count_r - CW'(1);
            end
          end
          CmdFree: if (slot_ok && !on_free && free_count_r < CW'(NUM_SLOTS)) begin
            free_ring_r[free_tail] <= slot_r[AW-1:0];
            free_count_r <= free_count_r + CW'(1);
          end
          CmdEnable: if (slot_ok && !in_act && active_count_r < CW'(NUM_SLOTS)) begin
            active_r[active_count_r[AW-1:0]] <= slot_r[AW-1:0];
            active_count_r <= active_count_r + CW'(1);
          end
          default: ;
        endcase
      end
      if (ac_shift_one && slot_ok && in_act) begin
        for (int i = 0; i < NUM_SLOTS - 1; i++)
          if (CW'(i) >= act_pos) active_r[i] <= active_r[i + 1];
        active_count_r <= active_count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_command;
      slot_r <= in_slot;
      has_remote_r <= in_has_remote;
      rport_r <= in_remote_port;
      raddr_r <= in_remote_addr;
      dport_r <= in_pkt_dest_port;
      sport_r <= in_pkt_src_port;
      saddr_r <= in_pkt_src_addr;
    end
    ost_r <= ost_nxt;
    oslot_r <= oslot_nxt;
    oport_r <= oport_nxt;
  end

  assign out_status = ost_r;
  assign out_found_slot = oslot_r;
  assign out_local_port = oport_r;
endmodule

// ----- src/uct_ram.sv -----
module uct_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sim/tb_udp_connection_table.sv -----
module tb_udp_connection_table;
  timeunit 1ns;
  timeprecision 1ps;
  import uct_pkg::*;

  localparam int NS = 8;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  slot;
    logic        has_remote;
    logic [15:0] remote_port;
    logic [31:0] remote_addr;
    logic [15:0] pkt_dest_port;
    logic [15:0] pkt_src_port;
    logic [31:0] pkt_src_addr;
  } conn_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  found_slot;
    logic [15:0] local_port;
  } conn_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  conn_cmd_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [2:0] out_found_slot;
  logic [15:0] out_local_port;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  udp_connection_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_item.command), .in_slot(in_item.slot),
    .in_has_remote(in_item.has_remote), .in_remote_port(in_item.remote_port),
    .in_remote_addr(in_item.remote_addr), .in_pkt_dest_port(in_item.pkt_dest_port),
    .in_pkt_src_port(in_item.pkt_src_port), .in_pkt_src_addr(in_item.pkt_src_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_found_slot(out_found_slot),
    .out_local_port(out_local_port),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // table model
  logic [15:0] m_first_port, m_wrap_limit, m_wrap_base;
  logic [7:0]  m_hop;
  logic [15:0] m_lport[NS];
  logic [15:0] m_rport[NS];
  logic [31:0] m_raddr[NS];
  logic [2:0]  m_free_ring[NS];
  int          m_free_head, m_free_count;
  logic [2:0]  m_active[NS];
  int          m_active_count;
  logic [15:0] m_counter;

  conn_cmd_t  pending_cmds[$];
  conn_resp_t expected_resps[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0, hold_off = 0;
  longint cycles = 0;

  function automatic bit port_taken(input logic [15:0] p);
    if (p == 16'd0) return 1'b1;
    for (int i = 0; i < NS; i++) if (m_lport[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic conn_resp_t table_step(input conn_cmd_t c);
    conn_resp_t r;
    bit found;
    int pos;
    r = '0;
    case (c.command)
      CmdAlloc: begin
        if (m_free_count == 0) begin
          r.status = StatNoFree;
        end else begin
          r.found_slot = m_free_ring[m_free_head];
          m_free_head = (m_free_head + 1) % NS;
          m_free_count--;
          m_lport[r.found_slot] = '0;
        end
      end
      CmdFree: begin
        m_lport[c.slot] = '0;
        found = 1'b0;
        for (int i = 0; i < m_free_count; i++)
          if (m_free_ring[(m_free_head + i) % NS] == c.slot) found = 1'b1;
        if (!found && m_free_count < NS) begin
          m_free_ring[(m_free_head + m_free_count) % NS] = c.slot;
          m_free_count++;
        end
      end
      CmdConnect: begin
        for (int i = 0; i < NS + 2; i++) begin
          m_counter = m_counter + 16'd1;
          if (m_counter >= m_wrap_limit) m_counter = m_wrap_base;
          if (!port_taken(m_counter)) break;
        end
        m_lport[c.slot] = m_counter;
        m_rport[c.slot] = c.has_remote ? c.remote_port : 16'd0;
        m_raddr[c.slot] = c.has_remote ? c.remote_addr : 32'd0;
        r.local_port = m_counter;
      end
      CmdEnable: begin
        pos = -1;
        for (int i = 0; i < m_active_count; i++) if (m_active[i] == c.slot) pos = i;
        if (pos < 0 && m_active_count < NS) begin
          m_active[m_active_count] = c.slot;
          m_active_count++;
        end
      end
      CmdDisable: begin
        pos = -1;
        for (int i = 0; i < m_active_count; i++) if (m_active[i] == c.slot) pos = i;
        if (pos >= 0) begin
          for (int i = pos; i + 1 < m_active_count; i++) m_active[i] = m_active[i + 1];
          m_active_count--;
        end
      end
      CmdLookup: begin
        r.status = StatNoMatch;
        for (int i = 0; i < m_active_count; i++) begin
          logic [2:0] s;
          s = m_active[i];
          if (m_lport[s] != 0 && m_lport[s] == c.pkt_dest_port &&
              (m_rport[s] == 0 || m_rport[s] == c.pkt_src_port) &&
              (m_raddr[s] == 0 || m_raddr[s] == 32'hFFFF_FFFF ||
               m_raddr[s] == c.pkt_src_addr)) begin
            r.status = StatDone;
            r.found_slot = s;
            r.local_port = m_lport[s];
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_resps.push_back(table_step(in_item));
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_item <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    conn_resp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result status=%0d slot=%0d port=%0d", $realtime,
                   out_status, out_found_slot, out_local_port);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          if (out_status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                     out_status);
            errors++;
          end
          if (out_found_slot != want.found_slot) begin
            $display("%0t: found_slot expected %0d actual %0d", $realtime,
                     want.found_slot, out_found_slot);
            errors++;
          end
          if (out_local_port != want.local_port) begin
            $display("%0t: local_port expected %0d actual %0d", $realtime,
                     want.local_port, out_local_port);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      RegFirstPort: begin
        m_first_port = value;
        m_counter = value;
      end
      RegWrapLimit: m_wrap_limit = value;
      RegWrapBase: m_wrap_base = value;
      default: m_hop = value[7:0];
    endcase
  endtask

  function automatic conn_cmd_t make_cmd(input logic [2:0] op, input logic [2:0] s);
    conn_cmd_t c;
    c.command = op;
    c.slot = s;
    c.has_remote = 1'($urandom_range(1));
    c.remote_port = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
    case ($urandom_range(3))
      0: c.remote_addr = 32'd0;
      1: c.remote_addr = 32'hFFFF_FFFF;
      default: c.remote_addr = $urandom;
    endcase
    c.pkt_dest_port = 16'($urandom);
    c.pkt_src_port = 16'($urandom);
    c.pkt_src_addr = $urandom;
    return c;
  endfunction

  // lookup aimed at a connected slot when possible
  function automatic conn_cmd_t aimed_lookup();
    conn_cmd_t c;
    int s;
    c = make_cmd(CmdLookup, 3'd0);
    s = $urandom_range(NS - 1);
    if ($urandom_range(3) != 0 && m_lport[s] != 0) begin
      c.pkt_dest_port = m_lport[s];
      if ($urandom_range(3) != 0) c.pkt_src_port = m_rport[s];
      if ($urandom_range(3) != 0) c.pkt_src_addr = m_raddr[s];
    end
    return c;
  endfunction

  task automatic drain(input int extra);
    while (pending_cmds.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // random traffic; lookups are built from the model at queue time only roughly,
  // so queue in small batches and drain between them
  task automatic random_phase(input int count, input int s_idle, input int r_stall);
    send_idle = s_idle;
    recv_stall = r_stall;
    for (int n = 0; n < count; n += 10) begin
      for (int k = 0; k < 10; k++) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) pending_cmds.push_back(make_cmd(CmdAlloc, 3'($urandom)));
        else if (pick < 25) pending_cmds.push_back(make_cmd(CmdFree, 3'($urandom)));
        else if (pick < 45) pending_cmds.push_back(make_cmd(CmdConnect, 3'($urandom)));
        else if (pick < 60) pending_cmds.push_back(make_cmd(CmdEnable, 3'($urandom)));
        else if (pick < 67) pending_cmds.push_back(make_cmd(CmdDisable, 3'($urandom)));
        else if (pick < 97) pending_cmds.push_back(aimed_lookup());
        else pending_cmds.push_back(make_cmd(3'($urandom_range(6, 7)), 3'($urandom)));
      end
      drain(0);
    end
  endtask

  initial begin
    m_first_port = FirstPortRst;
    m_wrap_limit = WrapLimitRst;
    m_wrap_base = WrapBaseRst;
    m_hop = HopLimitRst;
    m_counter = FirstPortRst;
    for (int i = 0; i < NS; i++) begin
      m_lport[i] = '0;
      m_rport[i] = '0;
      m_raddr[i] = '0;
      m_active[i] = '0;
      m_free_ring[i] = 3'(i);
    end
    m_free_head = 0;
    m_free_count = NS;
    m_active_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default config
    for (int i = 0; i < NS; i++) pending_cmds.push_back(make_cmd(CmdAlloc, 3'd0));
    pending_cmds.push_back(make_cmd(CmdAlloc, 3'd0));
    pending_cmds.push_back(make_cmd(CmdFree, 3'd7));
    pending_cmds.push_back(make_cmd(CmdFree, 3'd7));
    pending_cmds.push_back(make_cmd(CmdConnect, 3'd0));
    pending_cmds.push_back(make_cmd(CmdConnect, 3'd7));
    pending_cmds.push_back(make_cmd(CmdEnable, 3'd0));
    pending_cmds.push_back(make_cmd(CmdEnable, 3'd0));
    pending_cmds.push_back(make_cmd(CmdEnable, 3'd7));
    pending_cmds.push_back(make_cmd(CmdDisable, 3'd3));
    pending_cmds.push_back(make_cmd(3'd6, 3'd1));
    pending_cmds.push_back(make_cmd(3'd7, 3'd2));
    drain(0);
    pending_cmds.push_back(aimed_lookup());
    pending_cmds.push_back(aimed_lookup());
    pending_cmds.push_back(make_cmd(CmdLookup, 3'd0));
    pending_cmds.push_back(make_cmd(CmdDisable, 3'd0));
    drain(4 * NS);

    // tiny port range forces the exhausted search
    write_reg(RegFirstPort, 16'd1);
    write_reg(RegWrapLimit, 16'd2);
    write_reg(RegWrapBase, 16'd1);
    write_reg(RegHopLimit, 16'd0);
    for (int i = 0; i < 4; i++) pending_cmds.push_back(make_cmd(CmdConnect, 3'(i)));
    drain(0);
    random_phase(100, 0, 0);
    drain(4 * NS);

    write_reg(RegFirstPort, 16'hFFFF);
    write_reg(RegWrapLimit, 16'hFFFF);
    write_reg(RegWrapBase, 16'hFFF8);
    write_reg(RegHopLimit, 16'h00FF);
    random_phase(150, 49, 0);
    drain(4 * NS);

    write_reg(RegFirstPort, 16'd1024);
    write_reg(RegWrapLimit, 16'd1040);
    write_reg(RegWrapBase, 16'd1030);
    random_phase(150, 0, 49);
    drain(4 * NS);

    write_reg(RegWrapLimit, 16'd32000);
    write_reg(RegWrapBase, 16'd4096);
    // long receiver hold-off while the sender keeps offering
    send_idle = 0;
    hold_off = 300;
    for (int i = 0; i < 30; i++) pending_cmds.push_back(make_cmd(CmdAlloc, 3'd0));
    drain(0);
    random_phase(170, 21, 21);
    drain(4 * NS + 20);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
